/* hw/rtl/mprd_pkg.sv */
`timescale 1ns / 1ps

package mprd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 10;
    localparam int PPR_W       = 8;
    localparam int RATE_W      = 40;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int DIV_STEPS   = RATE_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_JUMP_THRESHOLD    = 1'b0;
    localparam cfg_index_t REG_PULSES_PER_REPORT = 1'b1;

    localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST    = 10'd50;
    localparam logic [PPR_W-1:0]    PULSES_PER_REPORT_RST = 8'd2;

    // pulses per hour in thousandths: 3600 s/h * 1000 ms/s * 1000
    localparam logic [TIME_W-1:0] RATE_SCALE     = 32'd3600000000;
    localparam logic [RATE_W-1:0] RATE_SATURATED = 40'd918000000000;

endpackage

/* hw/rtl/mprd_if.sv */
`timescale 1ns / 1ps

interface mprd_in_if;
    logic                          valid;
    logic                          ready;
    logic [mprd_pkg::SAMPLE_W-1:0] sample;
    logic [mprd_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, output sample, output time_ms, input ready);
    modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

interface mprd_out_if;
    logic                          valid;
    logic                          ready;
    logic [mprd_pkg::SAMPLE_W-1:0] edge_sample;
    logic                          report_valid;
    logic [mprd_pkg::RATE_W-1:0]   rate_milli;
    logic                          zero_interval;

    modport source (output valid, output edge_sample, output report_valid,
                    output rate_milli, output zero_interval, input ready);
    modport sink   (input valid, input edge_sample, input report_valid,
                    input rate_milli, input zero_interval, output ready);
endinterface

/* hw/rtl/mprd_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle through a single
// 33-bit compare/subtract. Divisor must be nonzero.
module mprd_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mprd_pkg::RATE_W-1:0]   dividend,
    input  logic [mprd_pkg::TIME_W-1:0]   divisor,
    output logic                          done,
    output logic [mprd_pkg::RATE_W-1:0]   quotient
);

    logic [mprd_pkg::RATE_W-1:0]    quo_reg;
    logic [mprd_pkg::TIME_W-1:0]    rem_reg;
    logic [mprd_pkg::TIME_W-1:0]    dvs_reg;
    logic [mprd_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [mprd_pkg::TIME_W:0]   rem_shift;
    logic [mprd_pkg::TIME_W:0]   rem_diff;
    logic                        q_bit;
    logic [mprd_pkg::TIME_W-1:0] rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[mprd_pkg::RATE_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        q_bit     = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = q_bit ? rem_diff[mprd_pkg::TIME_W-1:0]
                          : rem_shift[mprd_pkg::TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mprd_pkg::DIV_CNT_W'(mprd_pkg::DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[mprd_pkg::RATE_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/meter_pulse_rate_detector.sv */
`timescale 1ns / 1ps
// A sample without an edge leaves the block in ST_IDLE. An edge without a report,
// or a report over a zero interval, goes through ST_DONE to the output register; a
// rate report goes through ST_MUL (multiply), ST_LOAD (divider load), ST_DIV
// (divider steps, quotient capture) and ST_DONE (result). ST_DONE waits while the
// output is full. Throughput: one sample at a time, taken only in ST_IDLE.
// Reset: asynchronous, active low; armed set, counters and time base cleared.
module meter_pulse_rate_detector
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mprd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mprd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    mprd_in_if.sink                            in_ch,
    mprd_out_if.source                         out_ch
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [mprd_pkg::THRESH_W-1:0] jump_threshold_reg;
    logic [mprd_pkg::PPR_W-1:0]    pulses_per_report_reg;

    logic [mprd_pkg::SAMPLE_W-1:0] prev_sample_reg;
    logic                          armed_reg;
    logic [mprd_pkg::PPR_W-1:0]    pulse_count_reg;
    logic [mprd_pkg::TIME_W-1:0]   last_time_reg;

    logic [mprd_pkg::SAMPLE_W-1:0] edge_sample_reg;
    logic                          report_reg;
    logic                          zero_reg;
    logic [mprd_pkg::PPR_W-1:0]    ppr_hold_reg;
    logic [mprd_pkg::TIME_W-1:0]   elapsed_reg;
    logic [mprd_pkg::RATE_W-1:0]   product_reg;
    logic [mprd_pkg::RATE_W-1:0]   rate_reg;

    logic                          out_valid_reg;
    logic [mprd_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                          out_report_reg;
    logic [mprd_pkg::RATE_W-1:0]   out_rate_reg;
    logic                          out_zero_reg;

    logic [mprd_pkg::SAMPLE_W:0]   limit;
    logic                          detect;
    logic [mprd_pkg::PPR_W-1:0]    count_inc;
    logic                          report_hit;
    logic [mprd_pkg::TIME_W-1:0]   elapsed;
    logic                          armed_next;
    logic [mprd_pkg::PPR_W-1:0]    pulse_count_next;
    logic                          in_beat;
    logic                          out_free;

    logic                          div_start;
    logic                          div_done;
    logic [mprd_pkg::RATE_W-1:0]   div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_threshold_reg    <= mprd_pkg::JUMP_THRESHOLD_RST;
            pulses_per_report_reg <= mprd_pkg::PULSES_PER_REPORT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mprd_pkg::REG_JUMP_THRESHOLD:
                    jump_threshold_reg <= cfg_wdata[mprd_pkg::THRESH_W-1:0];
                mprd_pkg::REG_PULSES_PER_REPORT:
                    pulses_per_report_reg <= cfg_wdata[mprd_pkg::PPR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        limit      = {1'b0, prev_sample_reg} + {1'b0, jump_threshold_reg};
        detect     = armed_reg && ({1'b0, in_ch.sample} > limit);
        count_inc  = pulse_count_reg + 1'b1;
        report_hit = (count_inc >= pulses_per_report_reg);
        elapsed    = in_ch.time_ms - last_time_reg;

        // re-arm can never fire on the sample that detected the edge
        if (detect)
            armed_next = 1'b0;
        else if (!armed_reg && ({1'b0, in_ch.sample} < limit))
            armed_next = 1'b1;
        else
            armed_next = armed_reg;

        if (detect)
            pulse_count_next = report_hit ? '0 : count_inc;
        else
            pulse_count_next = pulse_count_reg;
    end

    assign in_beat  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign div_start = (state_reg == ST_LOAD);

    mprd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (elapsed_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_sample_reg <= '0;
            armed_reg       <= 1'b1;
            pulse_count_reg <= '0;
            last_time_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // in ST_DONE the output register is reloaded instead
            if (out_valid_reg && out_ch.ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat)
                    begin
                        prev_sample_reg <= in_ch.sample;
                        armed_reg       <= armed_next;
                        pulse_count_reg <= pulse_count_next;
                        if (detect)
                        begin
                            edge_sample_reg <= in_ch.sample;
                            report_reg      <= report_hit;
                            zero_reg        <= report_hit && (elapsed == '0);
                            ppr_hold_reg    <= pulses_per_report_reg;
                            elapsed_reg     <= elapsed;
                            if (report_hit)
                                last_time_reg <= in_ch.time_ms;
                            if (!report_hit)
                            begin
                                rate_reg  <= '0;
                                state_reg <= ST_DONE;
                            end
                            else if (elapsed == '0)
                            begin
                                rate_reg  <= mprd_pkg::RATE_SATURATED;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                state_reg <= ST_MUL;
                            end
                        end
                    end
                end
                ST_MUL:
                begin
                    product_reg <= mprd_pkg::RATE_W'(ppr_hold_reg)
                                 * mprd_pkg::RATE_W'(mprd_pkg::RATE_SCALE);
                    state_reg   <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        rate_reg  <= div_quotient;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= edge_sample_reg;
                        out_report_reg <= report_reg;
                        out_rate_reg   <= rate_reg;
                        out_zero_reg   <= zero_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ch.ready          = (state_reg == ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.edge_sample   = out_sample_reg;
    assign out_ch.report_valid  = out_report_reg;
    assign out_ch.rate_milli    = out_rate_reg;
    assign out_ch.zero_interval = out_zero_reg;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE_CYCLES = 60;

    typedef struct {
        logic [mprd_pkg::SAMPLE_W-1:0] edge_sample;
        logic                          report_valid;
        logic [mprd_pkg::RATE_W-1:0]   rate_milli;
        logic                          zero_interval;
    } edge_result_t;

    // Tracks detector state and holds the edge beats still owed by the block.
    class pulse_scoreboard;
        bit [mprd_pkg::THRESH_W-1:0] thresh;
        bit [mprd_pkg::PPR_W-1:0]    per_report;
        bit [mprd_pkg::SAMPLE_W-1:0] prev_sample;
        bit                          armed;
        bit [mprd_pkg::PPR_W-1:0]    edge_count;
        bit [mprd_pkg::TIME_W-1:0]   last_report_ms;
        edge_result_t                pending_edges[$];
        int                          errors;

        function new();
            thresh         = mprd_pkg::JUMP_THRESHOLD_RST;
            per_report     = mprd_pkg::PULSES_PER_REPORT_RST;
            prev_sample    = '0;
            armed          = 1'b1;
            edge_count     = '0;
            last_report_ms = '0;
            errors         = 0;
        endfunction

        function void set_reg(mprd_pkg::cfg_index_t idx,
                              logic [mprd_pkg::CFG_DATA_W-1:0] val);
            if (idx == mprd_pkg::REG_JUMP_THRESHOLD)
                thresh = val[mprd_pkg::THRESH_W-1:0];
            else if (idx == mprd_pkg::REG_PULSES_PER_REPORT)
                per_report = val[mprd_pkg::PPR_W-1:0];
        endfunction

        function void note_sample(bit [mprd_pkg::SAMPLE_W-1:0] s,
                                  bit [mprd_pkg::TIME_W-1:0] t);
            bit [mprd_pkg::SAMPLE_W:0] trip;
            bit [mprd_pkg::TIME_W-1:0] elapsed;
            bit [63:0]                 quotient;
            edge_result_t              exp_edge;
            trip = {1'b0, prev_sample} + {1'b0, thresh};
            if (armed && {1'b0, s} > trip) begin
                armed = 1'b0;
                edge_count = edge_count + 1'b1;
                exp_edge.edge_sample   = s;
                exp_edge.report_valid  = 1'b0;
                exp_edge.rate_milli    = '0;
                exp_edge.zero_interval = 1'b0;
                // a count left above a lowered register value reports too
                if (edge_count >= per_report) begin
                    elapsed = t - last_report_ms;
                    exp_edge.report_valid = 1'b1;
                    if (elapsed == 0) begin
                        exp_edge.rate_milli    = mprd_pkg::RATE_SATURATED;
                        exp_edge.zero_interval = 1'b1;
                    end
                    else begin
                        quotient = (64'(per_report) * 64'(mprd_pkg::RATE_SCALE))
                                   / 64'(elapsed);
                        exp_edge.rate_milli = quotient[mprd_pkg::RATE_W-1:0];
                    end
                    edge_count     = '0;
                    last_report_ms = t;
                end
                pending_edges.push_back(exp_edge);
            end
            // re-arm is evaluated after detection, so never on the detecting sample
            if (!armed && {1'b0, s} < trip)
                armed = 1'b1;
            prev_sample = s;
        endfunction

        function void check_edge(edge_result_t got);
            edge_result_t exp_edge;
            if (pending_edges.size() == 0) begin
                $error("unexpected edge beat: edge_sample %0d", got.edge_sample);
                errors++;
                return;
            end
            exp_edge = pending_edges.pop_front();
            if (got.edge_sample !== exp_edge.edge_sample) begin
                $error("edge_sample: expected %0d, actual %0d",
                       exp_edge.edge_sample, got.edge_sample);
                errors++;
            end
            if (got.report_valid !== exp_edge.report_valid) begin
                $error("report_valid: expected %0d, actual %0d",
                       exp_edge.report_valid, got.report_valid);
                errors++;
            end
            if (got.rate_milli !== exp_edge.rate_milli) begin
                $error("rate_milli: expected %0d, actual %0d",
                       exp_edge.rate_milli, got.rate_milli);
                errors++;
            end
            if (got.zero_interval !== exp_edge.zero_interval) begin
                $error("zero_interval: expected %0d, actual %0d",
                       exp_edge.zero_interval, got.zero_interval);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    mprd_pkg::cfg_index_t            cfg_index;
    logic [mprd_pkg::CFG_DATA_W-1:0] cfg_wdata;

    mprd_in_if  in_ch();
    mprd_out_if out_ch();

    pulse_scoreboard sb = new();

    bit                int_no_idle_unused_guard = 1'b0;
    bit                no_idle = 1'b0;
    int                cycle_count = 0;

    // sample generator state
    bit [mprd_pkg::SAMPLE_W-1:0] last_s = '0;
    bit                          pulse_hi = 1'b0;
    bit [mprd_pkg::SAMPLE_W-1:0] base_level = '0;
    bit [mprd_pkg::THRESH_W-1:0] cur_thresh = mprd_pkg::JUMP_THRESHOLD_RST;
    bit [mprd_pkg::TIME_W-1:0]   now_ms = '0;

    meter_pulse_rate_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    task automatic write_reg(input mprd_pkg::cfg_index_t idx,
                             input logic [mprd_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
        if (idx == mprd_pkg::REG_JUMP_THRESHOLD)
            cur_thresh = val;
    endtask

    task automatic send_sample(input bit [mprd_pkg::SAMPLE_W-1:0] s,
                               input bit [mprd_pkg::TIME_W-1:0] t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= s;
        in_ch.time_ms <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_sample(s, t);
        last_s = s;
    endtask

    // stop sending until every owed edge beat is out, then let the block settle
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    always @(posedge clk) begin : edge_monitor
        edge_result_t got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.edge_sample   = out_ch.edge_sample;
            got.report_valid  = out_ch.report_valid;
            got.rate_milli    = out_ch.rate_milli;
            got.zero_interval = out_ch.zero_interval;
            sb.check_edge(got);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int                          n_items;
        int                          r;
        int unsigned                 v;
        bit [mprd_pkg::SAMPLE_W-1:0] s;
        bit [mprd_pkg::THRESH_W-1:0] thr;
        bit [mprd_pkg::PPR_W-1:0]    ppr;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= mprd_pkg::REG_JUMP_THRESHOLD;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.sample  <= '0;
        in_ch.time_ms <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: threshold 50, pulses per report 2
        send_sample(10'd0,    32'd0);
        send_sample(10'd51,   32'd10);          // edge, no report
        send_sample(10'd101,  32'd20);          // equal to trip level: stays disarmed
        send_sample(10'd150,  32'd30);          // re-arm
        send_sample(10'd1023, 32'd0);           // report over zero interval
        send_sample(10'd0,    32'd1);
        send_sample(10'd1023, 32'hFFFF_FFFF);
        send_sample(10'd0,    32'd5);
        send_sample(10'd1023, 32'd4);           // report, short interval
        send_sample(10'd0,    32'hFFFF_FFFF);
        send_sample(10'd1023, 32'd3);
        send_sample(10'd0,    32'd3);
        send_sample(10'd1023, 32'd3);           // elapsed wraps to all ones
        hold_until_drained();

        // zero threshold, report on every edge; upper data bits must be dropped
        write_reg(mprd_pkg::REG_JUMP_THRESHOLD, 10'd0);
        write_reg(mprd_pkg::REG_PULSES_PER_REPORT, 10'h301);
        send_sample(10'd5, 32'd100);
        send_sample(10'd6, 32'd101);
        send_sample(10'd6, 32'd102);
        send_sample(10'd5, 32'd103);
        send_sample(10'd6, 32'd103);
        hold_until_drained();

        // build up a count, then lower the group size under it
        write_reg(mprd_pkg::REG_PULSES_PER_REPORT, 10'd3);
        send_sample(10'd0, 32'd200);
        send_sample(10'd1, 32'd210);
        send_sample(10'd0, 32'd220);
        send_sample(10'd1, 32'd230);
        hold_until_drained();
        write_reg(mprd_pkg::REG_PULSES_PER_REPORT, 10'd1);
        send_sample(10'd0, 32'd240);
        send_sample(10'd2, 32'd250);
        hold_until_drained();

        // group size zero: every edge reports, with a zero rate unless the interval is zero
        write_reg(mprd_pkg::REG_PULSES_PER_REPORT, 10'd0);
        send_sample(10'd0, 32'd260);
        send_sample(10'd1, 32'd261);
        send_sample(10'd0, 32'd261);
        send_sample(10'd1, 32'd261);
        hold_until_drained();

        now_ms = $urandom();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin thr = 10'd50; ppr = 8'd2; end
                1: begin thr = 10'd0; ppr = 8'd255; end
                2: begin thr = 10'd1023; ppr = 8'd1; end
                3: begin
                    thr = mprd_pkg::THRESH_W'($urandom_range(1, 200));
                    ppr = 8'd1;
                end
                4: begin
                    thr = mprd_pkg::THRESH_W'($urandom_range(0, 400));
                    ppr = 8'd0;
                end
                5: begin
                    thr = mprd_pkg::THRESH_W'($urandom_range(1, 100));
                    ppr = mprd_pkg::PPR_W'($urandom_range(2, 8));
                end
                6: begin
                    thr = mprd_pkg::THRESH_W'($urandom_range(0, 1023));
                    ppr = mprd_pkg::PPR_W'($urandom_range(1, 255));
                end
                default: begin
                    thr = mprd_pkg::THRESH_W'($urandom_range(0, 60));
                    ppr = mprd_pkg::PPR_W'($urandom_range(1, 4));
                end
            endcase
            write_reg(mprd_pkg::REG_JUMP_THRESHOLD, thr);
            v = $urandom_range(0, 3);
            write_reg(mprd_pkg::REG_PULSES_PER_REPORT, {v[1:0], ppr});
            base_level = mprd_pkg::SAMPLE_W'($urandom_range(0, 300));
            pulse_hi = 1'b0;
            n_items = (ph == 2) ? 40 : 195;

            for (int k = 0; k < n_items; k++) begin
                if (k % 60 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);

                r = $urandom_range(0, 99);
                if (r < 12) begin
                    s = mprd_pkg::SAMPLE_W'($urandom_range(0, 1023));
                end
                else if (r < 18) begin
                    // right at the trip level or one above it
                    v = last_s + cur_thresh + (r % 2);
                    s = (v > 1023) ? 10'd1023 : v[mprd_pkg::SAMPLE_W-1:0];
                end
                else if (!pulse_hi) begin
                    if ($urandom_range(0, 2) == 0) begin
                        v = last_s + cur_thresh + 1 + $urandom_range(0, 150);
                        s = (v > 1023) ? 10'd1023 : v[mprd_pkg::SAMPLE_W-1:0];
                        pulse_hi = 1'b1;
                    end
                    else begin
                        v = base_level + $urandom_range(0, cur_thresh / 4 + 3);
                        s = (v > 1023) ? 10'd1023 : v[mprd_pkg::SAMPLE_W-1:0];
                    end
                end
                else if ($urandom_range(0, 1) == 0) begin
                    s = (last_s > 3)
                        ? mprd_pkg::SAMPLE_W'(last_s - $urandom_range(0, 3))
                        : last_s;
                end
                else begin
                    s = base_level;
                    pulse_hi = 1'b0;
                end

                r = $urandom_range(0, 99);
                if (r < 4)
                    v = 0;
                else if (r < 8)
                    v = $urandom();
                else if (r < 14)
                    v = $urandom_range(1000, 100000);
                else
                    v = $urandom_range(1, 150);
                now_ms = now_ms + v;

                send_sample(s, now_ms);

                if ($urandom_range(0, 199) == 0)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        if (sb.errors == 0 && sb.pending_edges.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mprd_pkg.sv
hw/rtl/mprd_if.sv
hw/rtl/mprd_div.sv
hw/rtl/meter_pulse_rate_detector.sv
sim/tb_top.sv
